// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define PVA_ASSERT_CLK(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
        else $error("voice allocator check failed");

// clocked assertion on clk and rst_n of the enclosing scope
`define PVA_ASSERT(lbl, prop) `PVA_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

// ===== src/pva_pkg.sv =====
package pva_pkg;

    localparam int ORDER_W  = 48;
    localparam int COUNT_W  = 24;
    localparam int PITCH_W  = 7;
    localparam int SPAN_W   = 16;
    localparam int IDX_W    = 4;
    localparam int REPORT_MAX = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [ORDER_W-1:0] ORDER_MAX     = {ORDER_W{1'b1}};
    localparam logic [COUNT_W-1:0] RELEASE_RESET = 24'd1;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_ALL_OFF  = 2'd2;
    localparam logic [1:0] OP_ADVANCE  = 2'd3;

    localparam logic REG_RELEASE = 1'b0;

    typedef enum logic [1:0] {
        K_ON,
        K_OFF,
        K_ALL,
        K_ADV
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic               active;
        logic               releasing;
        logic [PITCH_W-1:0] pitch;
        logic [PITCH_W-1:0] level;
        logic [ORDER_W-1:0] start_order;
        logic [ORDER_W-1:0] release_order;
        logic [COUNT_W-1:0] countdown;
    } voice_entry_t;

endpackage

// ===== src/pva_if.sv =====
interface pva_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] span_samples;

    modport source (output valid, opcode, note, velocity, span_samples, input ready);
    modport sink (input valid, opcode, note, velocity, span_samples, output ready);
endinterface

interface pva_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] voice_index;
    logic       found;
    logic       stolen;
    logic       gate;
    logic       active;
    logic [6:0] voice_note;
    logic [6:0] voice_velocity;
    logic       last;

    modport source (output valid, voice_index, found, stolen, gate, active, voice_note,
                    voice_velocity, last, input ready);
    modport sink (input valid, voice_index, found, stolen, gate, active, voice_note,
                  voice_velocity, last, output ready);
endinterface

// ===== src/pva_cfg.sv =====
module pva_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pva_pkg::APB_AW-1:0]    paddr,
    input  logic [pva_pkg::APB_DW-1:0]    pwdata,
    output logic [pva_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [pva_pkg::COUNT_W-1:0]   release_len
);

    logic [pva_pkg::COUNT_W-1:0] release_reg;
    logic                        hit;

    assign hit    = (paddr[pva_pkg::APB_AW-1] == pva_pkg::REG_RELEASE);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_reg <= pva_pkg::RELEASE_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            release_reg <= pwdata[pva_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata[pva_pkg::COUNT_W-1:0] = release_reg;
        end
    end

    // zero length behaves as one sample
    assign release_len = (release_reg == '0) ? pva_pkg::COUNT_W'(1) : release_reg;

endmodule

// ===== src/pva_voice_mem.sv =====
module pva_voice_mem #(
    parameter int VOICES = 16,
    parameter int IW     = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [IW-1:0]         rd_addr,
    output pva_pkg::voice_entry_t rd_data,
    input  logic                  wr_en,
    input  logic [IW-1:0]         wr_addr,
    input  pva_pkg::voice_entry_t wr_data
);

    pva_pkg::voice_entry_t mem [VOICES];
    logic [VOICES-1:0]     valid_reg;
    pva_pkg::voice_entry_t rdata_reg;
    logic                  rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== src/polyphonic_voice_allocator_unit.sv =====
// Voice allocator over a table of VOICES voices held in a single-port-read,
// single-port-write memory. Every item except a zero-span advance walks the
// table once, each voice in turn being read, then evaluated and written back;
// an advance's walk and the closing commit of other items wait while the
// result side stalls. A zero-span advance is taken while idle and gives no
// result. The memory read port sets the pace of the walk. Note on, note off
// and all-off give one result each; an advance gives one result per voice for
// the first sixteen voices, emitted during the walk, the final one marked last.
// Configuration: release_samples at byte address 0; write only while idle.
module polyphonic_voice_allocator_unit #(
    parameter int VOICES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pva_pkg::APB_AW-1:0]   paddr,
    input  logic [pva_pkg::APB_DW-1:0]   pwdata,
    output logic [pva_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    pva_cmd_if.sink                      cmd,
    pva_rsp_if.source                    rsp
);

    localparam int IW   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NREP = (VOICES < pva_pkg::REPORT_MAX) ? VOICES : pva_pkg::REPORT_MAX;
    localparam logic [IW-1:0] LAST_V = IW'(VOICES - 1);

    logic [pva_pkg::COUNT_W-1:0] release_len;

    pva_pkg::state_t state_reg, state_next;
    pva_pkg::kind_t  kind_reg, kind_next;
    logic [IW-1:0]   cnt_reg, cnt_next;
    logic [6:0]      note_reg, note_next, vel_reg, vel_next;
    logic [pva_pkg::SPAN_W-1:0] span_reg, span_next;
    logic [pva_pkg::ORDER_W-1:0] order_reg, order_next, order_inc;

    logic free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic rel_found_reg, rel_found_next;
    logic [pva_pkg::ORDER_W-1:0] rel_best_reg, rel_best_next;
    logic [IW-1:0] rel_idx_reg, rel_idx_next;
    logic [pva_pkg::ORDER_W-1:0] start_best_reg, start_best_next;
    logic [IW-1:0] start_idx_reg, start_idx_next;
    logic m_found_reg, m_found_next;
    logic [IW-1:0] m_idx_reg, m_idx_next;
    logic [pva_pkg::ORDER_W-1:0] m_start_reg, m_start_next;
    logic [6:0] m_level_reg, m_level_next;
    logic any_reg, any_next;

    logic ov_reg, ov_next;
    logic [3:0] o_idx_reg, o_idx_next;
    logic o_found_reg, o_found_next, o_stolen_reg, o_stolen_next;
    logic o_gate_reg, o_gate_next, o_active_reg, o_active_next;
    logic [6:0] o_note_reg, o_note_next, o_vel_reg, o_vel_next;
    logic o_last_reg, o_last_next;

    logic                  rd_en, wr_en;
    logic [IW-1:0]         rd_addr, wr_addr, sel_idx;
    pva_pkg::voice_entry_t rd_data, wr_data;
    logic                  slot_free, held, rep, adv_release;
    logic [IW+3:0]         idx_ext;

    pva_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .release_len (release_len)
    );

    pva_voice_mem #(
        .VOICES (VOICES),
        .IW     (IW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign order_inc = (order_reg == pva_pkg::ORDER_MAX) ? order_reg : order_reg + 1'b1;
    assign slot_free = !ov_reg || rsp.ready;
    assign held      = rd_data.active && !rd_data.releasing;
    assign rep       = (int'(cnt_reg) < NREP);
    assign adv_release = rd_data.active && rd_data.releasing;

    assign cmd.ready          = (state_reg == pva_pkg::ST_IDLE);
    assign rsp.valid          = ov_reg;
    assign rsp.voice_index    = o_idx_reg;
    assign rsp.found          = o_found_reg;
    assign rsp.stolen         = o_stolen_reg;
    assign rsp.gate           = o_gate_reg;
    assign rsp.active         = o_active_reg;
    assign rsp.voice_note     = o_note_reg;
    assign rsp.voice_velocity = o_vel_reg;
    assign rsp.last           = o_last_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        cnt_next = cnt_reg;
        note_next = note_reg;
        vel_next = vel_reg;
        span_next = span_reg;
        order_next = order_reg;
        free_found_next = free_found_reg;
        free_idx_next = free_idx_reg;
        rel_found_next = rel_found_reg;
        rel_best_next = rel_best_reg;
        rel_idx_next = rel_idx_reg;
        start_best_next = start_best_reg;
        start_idx_next = start_idx_reg;
        m_found_next = m_found_reg;
        m_idx_next = m_idx_reg;
        m_start_next = m_start_reg;
        m_level_next = m_level_reg;
        any_next = any_reg;
        ov_next = ov_reg && !rsp.ready;
        o_idx_next = o_idx_reg;
        o_found_next = o_found_reg;
        o_stolen_next = o_stolen_reg;
        o_gate_next = o_gate_reg;
        o_active_next = o_active_reg;
        o_note_next = o_note_reg;
        o_vel_next = o_vel_reg;
        o_last_next = o_last_reg;
        rd_en = 1'b0;
        rd_addr = cnt_reg;
        wr_en = 1'b0;
        wr_addr = cnt_reg;
        wr_data = rd_data;
        sel_idx = cnt_reg;

        case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    note_next = cmd.note;
                    vel_next = cmd.velocity;
                    span_next = cmd.span_samples;
                    cnt_next = '0;
                    free_found_next = 1'b0;
                    rel_found_next = 1'b0;
                    rel_best_next = pva_pkg::ORDER_MAX;
                    start_best_next = pva_pkg::ORDER_MAX;
                    start_idx_next = '0;
                    m_found_next = 1'b0;
                    any_next = 1'b0;
                    state_next = pva_pkg::ST_READ;
                    case (cmd.opcode)
                        pva_pkg::OP_NOTE_ON:
                            kind_next = (cmd.velocity != '0) ? pva_pkg::K_ON : pva_pkg::K_OFF;
                        pva_pkg::OP_NOTE_OFF:
                            kind_next = pva_pkg::K_OFF;
                        pva_pkg::OP_ALL_OFF:
                            kind_next = pva_pkg::K_ALL;
                        default:
                        begin
                            kind_next = pva_pkg::K_ADV;
                            if (cmd.span_samples == '0)
                            begin
                                state_next = pva_pkg::ST_IDLE;
                            end
                        end
                    endcase
                end
            end

            pva_pkg::ST_READ:
            begin
                rd_en = 1'b1;
                state_next = pva_pkg::ST_EVAL;
            end

            pva_pkg::ST_EVAL:
            begin
                case (kind_reg)
                    pva_pkg::K_ON:
                    begin
                        if (!rd_data.active && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next = cnt_reg;
                        end
                        if (adv_release &&
                            (!rel_found_reg || (rd_data.release_order < rel_best_reg)))
                        begin
                            rel_found_next = 1'b1;
                            rel_best_next = rd_data.release_order;
                            rel_idx_next = cnt_reg;
                        end
                        if (rd_data.start_order < start_best_reg)
                        begin
                            start_best_next = rd_data.start_order;
                            start_idx_next = cnt_reg;
                        end
                    end
                    pva_pkg::K_OFF:
                    begin
                        if (held && (rd_data.pitch == note_reg) &&
                            (!m_found_reg || (rd_data.start_order < m_start_reg)))
                        begin
                            m_found_next = 1'b1;
                            m_idx_next = cnt_reg;
                            m_start_next = rd_data.start_order;
                            m_level_next = rd_data.level;
                        end
                    end
                    pva_pkg::K_ALL:
                    begin
                        if (held)
                        begin
                            wr_en = 1'b1;
                            wr_data.releasing = 1'b1;
                            wr_data.release_order = order_inc;
                            wr_data.countdown = release_len;
                            order_next = order_inc;
                            any_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (rep && !slot_free)
                        begin
                            state_next = pva_pkg::ST_EVAL;
                        end
                        else
                        begin
                            if (rep)
                            begin
                                idx_ext = {4'b0, cnt_reg};
                                ov_next = 1'b1;
                                o_idx_next = idx_ext[3:0];
                                o_found_next = 1'b0;
                                o_stolen_next = 1'b0;
                                o_gate_next = held;
                                o_active_next = rd_data.active;
                                o_note_next = rd_data.active ? rd_data.pitch : '0;
                                o_vel_next = rd_data.active ? rd_data.level : '0;
                                o_last_next = (int'(cnt_reg) == NREP - 1);
                            end
                            if (adv_release)
                            begin
                                wr_en = 1'b1;
                                if (rd_data.countdown <= {8'b0, span_reg})
                                begin
                                    wr_data = '0;
                                end
                                else
                                begin
                                    wr_data.countdown = rd_data.countdown - {8'b0, span_reg};
                                end
                            end
                        end
                    end
                endcase

                if (!(kind_reg == pva_pkg::K_ADV && rep && !slot_free))
                begin
                    if (cnt_reg == LAST_V)
                    begin
                        state_next = (kind_reg == pva_pkg::K_ADV) ? pva_pkg::ST_IDLE
                                                                  : pva_pkg::ST_COMMIT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        state_next = pva_pkg::ST_READ;
                    end
                end
            end

            pva_pkg::ST_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = pva_pkg::ST_IDLE;
                    ov_next = 1'b1;
                    o_last_next = 1'b1;
                    o_stolen_next = 1'b0;
                    o_found_next = 1'b0;
                    o_gate_next = 1'b0;
                    o_active_next = 1'b0;
                    o_note_next = '0;
                    o_vel_next = '0;
                    o_idx_next = '0;
                    case (kind_reg)
                        pva_pkg::K_ON:
                        begin
                            sel_idx = free_found_reg ? free_idx_reg :
                                      (rel_found_reg ? rel_idx_reg : start_idx_reg);
                            wr_en = 1'b1;
                            wr_addr = sel_idx;
                            wr_data = '0;
                            wr_data.active = 1'b1;
                            wr_data.pitch = note_reg;
                            wr_data.level = vel_reg;
                            wr_data.start_order = order_inc;
                            order_next = order_inc;
                            idx_ext = {4'b0, sel_idx};
                            o_idx_next = idx_ext[3:0];
                            o_found_next = 1'b1;
                            o_stolen_next = !free_found_reg;
                            o_gate_next = 1'b1;
                            o_active_next = 1'b1;
                            o_note_next = note_reg;
                            o_vel_next = vel_reg;
                        end
                        pva_pkg::K_OFF:
                        begin
                            if (m_found_reg)
                            begin
                                sel_idx = m_idx_reg;
                                wr_en = 1'b1;
                                wr_addr = sel_idx;
                                wr_data.active = 1'b1;
                                wr_data.releasing = 1'b1;
                                wr_data.pitch = note_reg;
                                wr_data.level = m_level_reg;
                                wr_data.start_order = m_start_reg;
                                wr_data.release_order = order_inc;
                                wr_data.countdown = release_len;
                                order_next = order_inc;
                                idx_ext = {4'b0, sel_idx};
                                o_idx_next = idx_ext[3:0];
                                o_found_next = 1'b1;
                                o_active_next = 1'b1;
                                o_note_next = note_reg;
                                o_vel_next = m_level_reg;
                            end
                        end
                        default:
                        begin
                            o_found_next = any_reg;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase
        idx_ext = {4'b0, sel_idx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pva_pkg::ST_IDLE;
            kind_reg <= pva_pkg::K_ON;
            cnt_reg <= '0;
            order_reg <= '0;
            free_found_reg <= 1'b0;
            rel_found_reg <= 1'b0;
            m_found_reg <= 1'b0;
            any_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg <= kind_next;
            cnt_reg <= cnt_next;
            order_reg <= order_next;
            free_found_reg <= free_found_next;
            rel_found_reg <= rel_found_next;
            m_found_reg <= m_found_next;
            any_reg <= any_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
        vel_reg <= vel_next;
        span_reg <= span_next;
        free_idx_reg <= free_idx_next;
        rel_best_reg <= rel_best_next;
        rel_idx_reg <= rel_idx_next;
        start_best_reg <= start_best_next;
        start_idx_reg <= start_idx_next;
        m_idx_reg <= m_idx_next;
        m_start_reg <= m_start_next;
        m_level_reg <= m_level_next;
        o_idx_reg <= o_idx_next;
        o_found_reg <= o_found_next;
        o_stolen_reg <= o_stolen_next;
        o_gate_reg <= o_gate_next;
        o_active_reg <= o_active_next;
        o_note_reg <= o_note_next;
        o_vel_reg <= o_vel_next;
        o_last_reg <= o_last_next;
    end

endmodule

// ===== src/pva_checker.sv =====
`include "assert_macros.svh"

module pva_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [1:0]  cmd_opcode,
    input logic [15:0] cmd_span,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        found,
    input logic        stolen,
    input logic        gate,
    input logic        active,
    input logic [6:0]  voice_note,
    input logic [6:0]  voice_velocity
);

    logic cmd_take;

    assign cmd_take = cmd_valid && cmd_ready &&
                      !(cmd_opcode == pva_pkg::OP_ADVANCE && cmd_span == 16'd0);

    `PVA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
    `PVA_ASSERT(a_busy_after_cmd, cmd_take |=> !cmd_ready)
    `PVA_ASSERT(a_steal_is_on, rsp_valid && stolen |-> found && gate && active)
    `PVA_ASSERT(a_idle_voice_zero, rsp_valid && !active |-> !gate && voice_note == 7'd0 && voice_velocity == 7'd0)

endmodule

bind polyphonic_voice_allocator_unit pva_checker u_pva_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_opcode     (cmd.opcode),
    .cmd_span       (cmd.span_samples),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .found          (rsp.found),
    .stolen         (rsp.stolen),
    .gate           (rsp.gate),
    .active         (rsp.active),
    .voice_note     (rsp.voice_note),
    .voice_velocity (rsp.voice_velocity)
);
